>>> design/knng_pkg.sv
// Shared types and constants of the k-nearest-neighbour gesture classifier.
`default_nettype none

package knng_pkg;

   // Stream payload layout
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 8;
   localparam int SAMPLE_W   = 16;
   localparam int LABEL_W    = 4;
   localparam int ENTRY_W    = 3 * SAMPLE_W;

   localparam int REQ_PI_LSB = 0;
   localparam int REQ_FI_LSB = 8;
   localparam int REQ_X_LSB  = 14;
   localparam int REQ_Y_LSB  = 30;
   localparam int REQ_Z_LSB  = 46;
   localparam int REQ_LB_LSB = 62;

   // Commands carried on tuser
   localparam logic CMD_TRAIN = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Register indexes
   localparam logic [1:0] REG_NUM_FEATURES   = 2'd0;
   localparam logic [1:0] REG_NUM_TRAINING   = 2'd1;
   localparam logic [1:0] REG_NUM_CLASSES    = 2'd2;
   localparam logic [1:0] REG_NEIGHBOR_COUNT = 2'd3;

   localparam int CSR_DATA_W = 9;

   localparam logic [6:0] RST_NUM_FEATURES   = 7'd64;
   localparam logic [8:0] RST_NUM_TRAINING   = 9'd256;
   localparam logic [3:0] RST_NUM_CLASSES    = 4'd15;
   localparam logic [3:0] RST_NEIGHBOR_COUNT = 4'd7;

   // Classification job, sized for the widest parameter range
   typedef struct packed {
      logic [8:0]  nf;
      logic [12:0] nt;
      logic [5:0]  nc;
      logic [4:0]  k;
   } job_type;

endpackage

`default_nettype wire

>>> design/knng_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module knng_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> design/knng_queue.sv
// Two-entry job queue between the front end and the classification engine.
`default_nettype none

module knng_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire knng_pkg::job_type push_job,
   input  wire logic              pop,
   output logic                   job_valid,
   output knng_pkg::job_type      job,
   output logic                   full
);

   knng_pkg::job_type slot_ff [2];
   logic              wptr_ff, wptr_in;
   logic              rptr_ff, rptr_in;
   logic [1:0]        count_ff, count_in;

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

   assign job_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign job       = slot_ff[rptr_ff];

endmodule

`default_nettype wire

>>> design/knng_isqrt.sv
// Bit-serial floored integer square root, one result bit per cycle.
`default_nettype none

module knng_isqrt #(
   parameter int SQW = 38
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [SQW-1:0]     radicand,
   output logic                    done,
   output logic      [SQW/2-1:0]   root
);

   localparam int RW = SQW / 2;
   localparam int CNTW = $clog2(RW + 1);

   logic [SQW-1:0]  n_ff, n_in;
   logic [RW+1:0]   rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            done_ff, done_in;
   logic [RW+1:0]   rn, trial;

   always_comb begin
      n_in    = n_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rn      = {rem_ff[RW-1:0], n_ff[SQW-1:SQW-2]};
      trial   = {root_ff, 2'b01};
      if (start) begin
         n_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNTW'(RW);
      end else if (cnt_ff != '0) begin
         n_in   = {n_ff[SQW-3:0], 2'b00};
         cnt_in = cnt_ff - 1'b1;
         if (rn >= trial) begin
            rem_in  = rn - trial;
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rn;
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         done_in = (cnt_ff == CNTW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

>>> design/knng_front.sv
// Front end: register writes, input decode, store writes and job issue.
`default_nettype none

module knng_front #(
   parameter int MAX_TRAIN    = 256,
   parameter int MAX_FEATURES = 64,
   parameter int MAX_CLASSES  = 16,
   parameter int MAX_K        = 15,
   parameter int TAW          = 14,
   parameter int QAW          = 6,
   parameter int LAW          = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [knng_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tuser,
   input  wire logic                            req_tlast,
   input  wire logic                            csr_we,
   input  wire logic [1:0]                      csr_addr,
   input  wire logic [knng_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            stall,
   output logic                                 tr_wr,
   output logic      [TAW-1:0]                  tr_addr,
   output logic      [knng_pkg::ENTRY_W-1:0]    tr_data,
   output logic                                 q_wr,
   output logic      [QAW-1:0]                  q_addr,
   output logic                                 lb_wr,
   output logic      [LAW-1:0]                  lb_addr,
   output logic      [knng_pkg::LABEL_W-1:0]    lb_data,
   output logic                                 job_push,
   output knng_pkg::job_type                    job
);

   logic [6:0] nf_ff, nf_in;
   logic [8:0] nt_ff, nt_in;
   logic [3:0] nc_ff, nc_in;
   logic [3:0] k_ff, k_in;

   logic        accept;
   logic [7:0]  pi;
   logic [5:0]  fi;
   logic [31:0] nt_sat, k_sat;

   always_comb begin
      nf_in = nf_ff;
      nt_in = nt_ff;
      nc_in = nc_ff;
      k_in  = k_ff;
      if (csr_we) begin
         case (csr_addr)
            knng_pkg::REG_NUM_FEATURES:   nf_in = csr_wdata[6:0];
            knng_pkg::REG_NUM_TRAINING:   nt_in = csr_wdata[8:0];
            knng_pkg::REG_NUM_CLASSES:    nc_in = csr_wdata[3:0];
            knng_pkg::REG_NEIGHBOR_COUNT: k_in  = csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nf_ff <= knng_pkg::RST_NUM_FEATURES;
         nt_ff <= knng_pkg::RST_NUM_TRAINING;
         nc_ff <= knng_pkg::RST_NUM_CLASSES;
         k_ff  <= knng_pkg::RST_NEIGHBOR_COUNT;
      end else begin
         nf_ff <= nf_in;
         nt_ff <= nt_in;
         nc_ff <= nc_in;
         k_ff  <= k_in;
      end
   end

   assign req_tready = !stall;
   assign accept     = req_tvalid && !stall;
   assign pi         = req_tdata[knng_pkg::REQ_PI_LSB +: 8];
   assign fi         = req_tdata[knng_pkg::REQ_FI_LSB +: 6];

   assign tr_data = req_tdata[knng_pkg::REQ_X_LSB +: knng_pkg::ENTRY_W];
   assign tr_addr = TAW'(32'(pi) * MAX_FEATURES + 32'(fi));
   assign tr_wr   = accept && (req_tuser == knng_pkg::CMD_TRAIN)
                    && (32'(pi) < MAX_TRAIN) && (32'(fi) < MAX_FEATURES);
   assign lb_wr   = tr_wr;
   assign lb_addr = LAW'(pi);
   assign lb_data = req_tdata[knng_pkg::REQ_LB_LSB +: knng_pkg::LABEL_W];
   assign q_addr  = QAW'(fi);
   assign q_wr    = accept && (req_tuser == knng_pkg::CMD_QUERY)
                    && (32'(fi) < MAX_FEATURES);
   assign job_push = accept && (req_tuser == knng_pkg::CMD_QUERY) && req_tlast;

   // Saturate the registers against the build limits
   always_comb begin
      nt_sat = (32'(nt_ff) > MAX_TRAIN) ? 32'(MAX_TRAIN) : 32'(nt_ff);
      k_sat  = (32'(k_ff) > MAX_K) ? 32'(MAX_K) : 32'(k_ff);
      if (k_sat > nt_sat) begin
         k_sat = nt_sat;
      end
      job.nf = (32'(nf_ff) > MAX_FEATURES) ? 9'(MAX_FEATURES) : 9'(nf_ff);
      job.nt = 13'(nt_sat);
      job.nc = (32'(nc_ff) > MAX_CLASSES - 1) ? 6'(MAX_CLASSES - 1) : 6'(nc_ff);
      job.k  = 5'(k_sat);
   end

endmodule

`default_nettype wire

>>> design/knng_back.sv
// Classification engine: distance walk, nearest-k list and vote.
`default_nettype none

module knng_back #(
   parameter int MAX_TRAIN    = 256,
   parameter int MAX_FEATURES = 64,
   parameter int MAX_CLASSES  = 16,
   parameter int MAX_K        = 15,
   parameter int TAW          = 14,
   parameter int QAW          = 6,
   parameter int LAW          = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            job_valid,
   input  wire knng_pkg::job_type               job,
   output logic                                 job_pop,
   output logic                                 busy,
   output logic      [TAW-1:0]                  tr_rd_addr,
   input  wire logic [knng_pkg::ENTRY_W-1:0]    tr_rd_data,
   output logic      [QAW-1:0]                  q_rd_addr,
   input  wire logic [knng_pkg::ENTRY_W-1:0]    q_rd_data,
   output logic      [LAW-1:0]                  lb_rd_addr,
   input  wire logic [knng_pkg::LABEL_W-1:0]    lb_rd_data,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [knng_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int SQW = ((32 + $clog2(MAX_FEATURES + 1) + 1) / 2) * 2;
   localparam int RW  = SQW / 2;
   localparam int DW  = RW + 2;
   localparam int FW  = $clog2(MAX_FEATURES + 1);
   localparam int IW  = $clog2(MAX_TRAIN + 1);
   localparam int KW  = $clog2(MAX_K + 1);
   localparam int KIW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int CW  = $clog2(MAX_CLASSES);
   localparam int VW  = KW;
   localparam int SW  = knng_pkg::SAMPLE_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ACCUM, ST_SQRT, ST_INSERT, ST_VOTE, ST_PICK, ST_SEND
   } state_type;

   state_type        state_ff, state_in;
   logic [FW-1:0]    nf_ff, nf_in;
   logic [IW-1:0]    nt_ff, nt_in;
   logic [CW-1:0]    nc_ff, nc_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [IW-1:0]    i_ff, i_in;
   logic [TAW-1:0]   base_ff, base_in;
   logic [FW-1:0]    fi_ff, fi_in;
   logic             v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic [SW-1:0]    ad_ff [3];
   logic [SW-1:0]    ad_in [3];
   logic [2*SW-1:0]  sq_ff [3];
   logic [2*SW-1:0]  sq_in [3];
   logic [SQW-1:0]   acc_ff [3];
   logic [SQW-1:0]   acc_in [3];
   logic             sqrt_start_ff, sqrt_start_in;
   logic [DW-1:0]    bd_ff [MAX_K];
   logic [DW-1:0]    bd_in [MAX_K];
   logic [knng_pkg::LABEL_W-1:0] bl_ff [MAX_K];
   logic [knng_pkg::LABEL_W-1:0] bl_in [MAX_K];
   logic [KW-1:0]    filled_ff, filled_in;
   logic [KW-1:0]    vj_ff, vj_in;
   logic [VW-1:0]    votes_ff [MAX_CLASSES];
   logic [VW-1:0]    votes_in [MAX_CLASSES];
   logic [CW-1:0]    pj_ff, pj_in;
   logic [CW-1:0]    best_ff, best_in;
   logic [VW-1:0]    cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [knng_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic             issue;
   logic [2:0]       sq_done;
   logic [RW-1:0]    root [3];
   logic [DW-1:0]    cand_dist;
   logic [MAX_K-1:0] lt;
   logic [knng_pkg::LABEL_W-1:0] vlab;
   logic [5:0]       cnt_wide;
   logic signed [SW:0] diff;

   for (genvar a = 0; a < 3; a++) begin : g_root
      knng_isqrt #(.SQW(SQW)) u_isqrt (
         .clock    (clock),
         .reset    (reset),
         .start    (sqrt_start_ff),
         .radicand (acc_ff[a]),
         .done     (sq_done[a]),
         .root     (root[a])
      );
   end

   assign issue      = (state_ff == ST_ACCUM) && (fi_ff < nf_ff);
   assign tr_rd_addr = base_ff + TAW'(fi_ff);
   assign q_rd_addr  = QAW'(fi_ff);
   assign lb_rd_addr = LAW'(i_ff);
   assign cand_dist  = DW'(root[0]) + DW'(root[1]) + DW'(root[2]);
   assign vlab       = bl_ff[vj_ff[KIW-1:0]];

   always_comb begin
      state_in      = state_ff;
      nf_in         = nf_ff;
      nt_in         = nt_ff;
      nc_in         = nc_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      base_in       = base_ff;
      fi_in         = fi_ff;
      sqrt_start_in = 1'b0;
      bd_in         = bd_ff;
      bl_in         = bl_ff;
      filled_in     = filled_ff;
      vj_in         = vj_ff;
      votes_in      = votes_ff;
      pj_in         = pj_ff;
      best_in       = best_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      job_pop       = 1'b0;
      cnt_wide      = 6'(cnt_ff);
      diff          = '0;

      // Feature pipeline: read, difference, square, accumulate
      v1_in = issue;
      v2_in = v1_ff;
      v3_in = v2_ff;
      if (issue) begin
         fi_in = fi_ff + 1'b1;
      end
      for (int a = 0; a < 3; a++) begin
         diff = $signed({tr_rd_data[a*SW + SW-1], tr_rd_data[a*SW +: SW]})
                - $signed({q_rd_data[a*SW + SW-1], q_rd_data[a*SW +: SW]});
         ad_in[a]  = diff[SW] ? SW'(-diff) : diff[SW-1:0];
         sq_in[a]  = (2*SW)'(ad_ff[a]) * (2*SW)'(ad_ff[a]);
         acc_in[a] = v3_ff ? acc_ff[a] + SQW'(sq_ff[a]) : acc_ff[a];
      end

      // Sorted-list insertion; an empty slot ranks farther than any distance
      for (int j = 0; j < MAX_K; j++) begin
         lt[j] = (KW'(j) >= filled_ff) || (cand_dist < bd_ff[j]);
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop   = 1'b1;
               nf_in     = FW'(job.nf);
               nt_in     = IW'(job.nt);
               nc_in     = CW'(job.nc);
               k_in      = KW'(job.k);
               i_in      = '0;
               base_in   = '0;
               fi_in     = '0;
               filled_in = '0;
               vj_in     = '0;
               for (int c = 0; c < MAX_CLASSES; c++) begin
                  votes_in[c] = '0;
               end
               for (int a = 0; a < 3; a++) begin
                  acc_in[a] = '0;
               end
               state_in = (job.k == 5'd0) ? ST_VOTE : ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (!issue && !v1_ff && !v2_ff && !v3_ff) begin
               sqrt_start_in = 1'b1;
               state_in      = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_done[0]) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            if (lt[0]) begin
               bd_in[0] = cand_dist;
               bl_in[0] = lb_rd_data;
            end
            for (int j = 1; j < MAX_K; j++) begin
               if ((KW'(j) < k_ff) && lt[j]) begin
                  bd_in[j] = lt[j-1] ? bd_ff[j-1] : cand_dist;
                  bl_in[j] = lt[j-1] ? bl_ff[j-1] : lb_rd_data;
               end
            end
            if (filled_ff < k_ff) begin
               filled_in = filled_ff + 1'b1;
            end
            i_in    = i_ff + 1'b1;
            base_in = base_ff + TAW'(MAX_FEATURES);
            fi_in   = '0;
            for (int a = 0; a < 3; a++) begin
               acc_in[a] = '0;
            end
            state_in = (i_ff + 1'b1 == nt_ff) ? ST_VOTE : ST_ACCUM;
         end
         ST_VOTE: begin
            if (vj_ff < filled_ff) begin
               if (32'(vlab) <= 32'(nc_ff)) begin
                  votes_in[CW'(vlab)] = votes_ff[CW'(vlab)] + 1'b1;
               end
               vj_in = vj_ff + 1'b1;
            end else begin
               pj_in    = '0;
               best_in  = '0;
               cnt_in   = '0;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (votes_ff[pj_ff] > cnt_ff) begin
               cnt_in  = votes_ff[pj_ff];
               best_in = pj_ff;
            end
            if (pj_ff == nc_ff) begin
               state_in = ST_SEND;
            end else begin
               pj_in = pj_ff + 1'b1;
            end
         end
         ST_SEND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(cnt_wide > 6'd15) ? 4'd15 : cnt_wide[3:0], 4'(best_ff)};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         sqrt_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         filled_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         v3_ff         <= v3_in;
         sqrt_start_ff <= sqrt_start_in;
         rsp_valid_ff  <= rsp_valid_in;
         filled_ff     <= filled_in;
      end
      nf_ff       <= nf_in;
      nt_ff       <= nt_in;
      nc_ff       <= nc_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      base_ff     <= base_in;
      fi_ff       <= fi_in;
      ad_ff       <= ad_in;
      sq_ff       <= sq_in;
      acc_ff      <= acc_in;
      bd_ff       <= bd_in;
      bl_ff       <= bl_in;
      vj_ff       <= vj_in;
      votes_ff    <= votes_in;
      pj_ff       <= pj_in;
      best_ff     <= best_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> design/knn_gesture_classifier.sv
// Top level of the k-nearest-neighbour gesture classifier.
//
//  Channel | Ports               | Direction | Transfer
//  --------+---------------------+-----------+-------------------------------------------
//  req     | req_t{valid,ready}  | in        | training or query feature, one per transfer
//  rsp     | rsp_t{valid,ready}  | out       | winning class and its vote total
//  csr     | csr_we/addr/wdata   | in        | register write, no wait, no read-back
//
//  Load and query features are taken one per cycle and stream back to back while no job is queued or running.
//  A query transfer with tlast set starts a walk over all training points: per point
//  the features are read from the training and query RAMs, then the bit-serial square
//  root is started and run, then the point is inserted in the nearest-k list;
//  afterwards the filled entries (k at most) vote, an argmax runs over classes 0 to nc
//  and the result is loaded. req_tready stays low from the job hand-over to the end.
//  Reset is synchronous; the stores hold no reset state and need no clearing pass.
//  A result that waits on rsp_tready holds in the output register; the next query
//  that finishes waits behind it.
`default_nettype none

module knn_gesture_classifier #(
   parameter int MAX_TRAIN    = 256,
   parameter int MAX_FEATURES = 64,
   parameter int MAX_CLASSES  = 16,
   parameter int MAX_K        = 15
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // point_index[7:0] feature_index[13:8] sample_x[29:14] sample_y[45:30]
   // sample_z[61:46] label[65:62], zero above
   input  wire logic [knng_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  wire logic                            req_tuser,
   // last
   input  wire logic                            req_tlast,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // gesture_class[3:0] vote_total[7:4]
   output logic      [knng_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                            csr_we,
   input  wire logic [1:0]                      csr_addr,
   input  wire logic [knng_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int TDEPTH = MAX_TRAIN * MAX_FEATURES;
   localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
   localparam int QAW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int LAW    = (MAX_TRAIN > 1) ? $clog2(MAX_TRAIN) : 1;

   // Store write side (front end)
   logic                            tr_wr, q_wr, lb_wr;
   logic [TAW-1:0]                  tr_addr;
   logic [QAW-1:0]                  q_addr;
   logic [LAW-1:0]                  lb_addr;
   logic [knng_pkg::ENTRY_W-1:0]    tr_data;
   logic [knng_pkg::LABEL_W-1:0]    lb_data;

   // Store read side (engine)
   logic [TAW-1:0]                  tr_rd_addr;
   logic [QAW-1:0]                  q_rd_addr;
   logic [LAW-1:0]                  lb_rd_addr;
   logic [knng_pkg::ENTRY_W-1:0]    tr_rd_data, q_rd_data;
   logic [knng_pkg::LABEL_W-1:0]    lb_rd_data;

   // Job hand-over
   logic                            job_push, job_pop, job_valid, q_full;
   knng_pkg::job_type               push_job, job;
   logic                            back_busy, stall;

   // Hold the input off while any job is queued or running: the walk reads the stores
   assign stall = back_busy || job_valid || q_full;

   knng_front #(
      .MAX_TRAIN(MAX_TRAIN), .MAX_FEATURES(MAX_FEATURES),
      .MAX_CLASSES(MAX_CLASSES), .MAX_K(MAX_K),
      .TAW(TAW), .QAW(QAW), .LAW(LAW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .stall      (stall),
      .tr_wr      (tr_wr),
      .tr_addr    (tr_addr),
      .tr_data    (tr_data),
      .q_wr       (q_wr),
      .q_addr     (q_addr),
      .lb_wr      (lb_wr),
      .lb_addr    (lb_addr),
      .lb_data    (lb_data),
      .job_push   (job_push),
      .job        (push_job)
   );

   knng_ram #(.WIDTH(knng_pkg::ENTRY_W), .DEPTH(TDEPTH)) u_train_ram (
      .clock   (clock),
      .wr_en   (tr_wr),
      .wr_addr (tr_addr),
      .wr_data (tr_data),
      .rd_addr (tr_rd_addr),
      .rd_data (tr_rd_data)
   );

   knng_ram #(.WIDTH(knng_pkg::ENTRY_W), .DEPTH(MAX_FEATURES)) u_query_ram (
      .clock   (clock),
      .wr_en   (q_wr),
      .wr_addr (q_addr),
      .wr_data (tr_data),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   knng_ram #(.WIDTH(knng_pkg::LABEL_W), .DEPTH(MAX_TRAIN)) u_label_ram (
      .clock   (clock),
      .wr_en   (lb_wr),
      .wr_addr (lb_addr),
      .wr_data (lb_data),
      .rd_addr (lb_rd_addr),
      .rd_data (lb_rd_data)
   );

   knng_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .pop       (job_pop),
      .job_valid (job_valid),
      .job       (job),
      .full      (q_full)
   );

   knng_back #(
      .MAX_TRAIN(MAX_TRAIN), .MAX_FEATURES(MAX_FEATURES),
      .MAX_CLASSES(MAX_CLASSES), .MAX_K(MAX_K),
      .TAW(TAW), .QAW(QAW), .LAW(LAW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job        (job),
      .job_pop    (job_pop),
      .busy       (back_busy),
      .tr_rd_addr (tr_rd_addr),
      .tr_rd_data (tr_rd_data),
      .q_rd_addr  (q_rd_addr),
      .q_rd_data  (q_rd_data),
      .lb_rd_addr (lb_rd_addr),
      .lb_rd_data (lb_rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // No store write may land while a walk reads the stores
   a_no_write_during_walk: assert property (@(posedge clock) disable iff (reset)
      (tr_wr || q_wr || lb_wr) |-> (!back_busy && !job_valid))
      else $error("store written during classification");

   // A query with tlast set leaves a job queued on the next cycle
   a_job_follows_last: assert property (@(posedge clock) disable iff (reset)
      job_push |=> (job_valid || back_busy))
      else $error("classification job lost");

   // Without votes the class must fall back to zero
   a_no_vote_class_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[7:4] == 4'd0)) |-> (rsp_tdata[3:0] == 4'd0))
      else $error("class reported without votes");

   // The queue never pops while empty
   a_pop_when_valid: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid)
      else $error("job popped from empty queue");

endmodule

`default_nettype wire

>>> tb/sv/knn_gesture_classifier_tb.sv
// Self-checking stream testbench for the k-nearest-neighbour gesture classifier.
`timescale 1ns / 1ps

module knn_gesture_classifier_tb;

   localparam int POINTS   = 256;
   localparam int FEATS    = 64;
   localparam int KMAX     = 15;
   localparam int WDOG_MAX = 200000;

   typedef struct {
      logic        cmd;
      logic [7:0]  point;
      logic [5:0]  feat;
      logic [15:0] sx;
      logic [15:0] sy;
      logic [15:0] sz;
      logic [3:0]  label;
      logic        last;
   } feature_type;

   typedef struct {
      logic [3:0] gesture;
      logic [3:0] votes;
   } verdict_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [knng_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tuser = knng_pkg::CMD_TRAIN;
   logic                            req_tlast = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [knng_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_we = 1'b0;
   logic [1:0]                      csr_addr = knng_pkg::REG_NUM_FEATURES;
   logic [knng_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   knn_gesture_classifier u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Pending features waiting for the driver, and verdicts waiting for the monitor
   feature_type feature_feed[$];
   verdict_type verdicts_due[$];
   int          failures = 0;
   int          verdicts_seen = 0;
   int          features_sent = 0;
   int          phases_run = 0;

   // Mirror of the block: stores and registers
   shortint    mir_x[POINTS*FEATS];
   shortint    mir_y[POINTS*FEATS];
   shortint    mir_z[POINTS*FEATS];
   logic [3:0] mir_label[POINTS];
   shortint    qry_x[FEATS];
   shortint    qry_y[FEATS];
   shortint    qry_z[FEATS];
   int         cfg_nf = 64, cfg_nt = 256, cfg_nc = 15, cfg_k = 7;

   // Generator-side bookkeeping of which entries have been written
   bit trained[POINTS*FEATS];
   bit labelled[POINTS];
   bit queried[FEATS];

   function automatic longint unsigned floor_root(input longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b    = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n    = n - (root + b);
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic int gesture_distance(input int p);
      longint unsigned sq_x, sq_y, sq_z;
      longint dx, dy, dz;
      sq_x = 0; sq_y = 0; sq_z = 0;
      for (int f = 0; f < cfg_nf; f++) begin
         dx = longint'(mir_x[p*FEATS+f]) - longint'(qry_x[f]);
         dy = longint'(mir_y[p*FEATS+f]) - longint'(qry_y[f]);
         dz = longint'(mir_z[p*FEATS+f]) - longint'(qry_z[f]);
         sq_x += dx * dx;
         sq_y += dy * dy;
         sq_z += dz * dz;
      end
      return int'(floor_root(sq_x) + floor_root(sq_y) + floor_root(sq_z));
   endfunction

   // Rank training points, keep the k nearest (earlier point wins a tie), then vote
   function automatic verdict_type classify_gesture();
      int          near_d[KMAX];
      logic [3:0]  near_l[KMAX];
      int          tally[16];
      int          k, filled, pos, d, best, cnt;
      verdict_type v;
      k = (cfg_k > cfg_nt) ? cfg_nt : cfg_k;
      filled = 0;
      foreach (tally[c]) tally[c] = 0;
      for (int i = 0; i < cfg_nt && k > 0; i++) begin
         d   = gesture_distance(i);
         pos = 0;
         while (pos < filled && !(d < near_d[pos])) pos++;
         if (pos < k) begin
            if (filled < k) filled++;
            for (int j = filled - 1; j > pos; j--) begin
               near_d[j] = near_d[j-1];
               near_l[j] = near_l[j-1];
            end
            near_d[pos] = d;
            near_l[pos] = mir_label[i];
         end
      end
      for (int j = 0; j < filled; j++)
         if (near_l[j] <= cfg_nc) tally[near_l[j]]++;
      best = 0;
      cnt  = 0;
      for (int c = 0; c <= cfg_nc; c++)
         if (tally[c] > cnt) begin
            cnt  = tally[c];
            best = c;
         end
      v.gesture = best[3:0];
      v.votes   = (cnt > 15) ? 4'd15 : cnt[3:0];
      return v;
   endfunction

   // Predict on accepted request transfers and check accepted result transfers
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;
   int   quiet_cycles = 0;

   always @(posedge clock) begin
      int          p, f;
      verdict_type want;
      req_took <= req_tvalid && req_tready;
      rsp_took <= rsp_tvalid && rsp_tready;
      if (!reset && csr_we) begin
         case (csr_addr)
            knng_pkg::REG_NUM_FEATURES:
               cfg_nf = (csr_wdata[6:0] > FEATS) ? FEATS : csr_wdata[6:0];
            knng_pkg::REG_NUM_TRAINING:
               cfg_nt = (csr_wdata > POINTS) ? POINTS : csr_wdata;
            knng_pkg::REG_NUM_CLASSES:    cfg_nc = csr_wdata[3:0];
            knng_pkg::REG_NEIGHBOR_COUNT: cfg_k  = csr_wdata[3:0];
            default: begin
            end
         endcase
      end
      if (!reset && req_tvalid && req_tready) begin
         p = req_tdata[knng_pkg::REQ_PI_LSB +: 8];
         f = req_tdata[knng_pkg::REQ_FI_LSB +: 6];
         if (req_tuser == knng_pkg::CMD_TRAIN) begin
            mir_x[p*FEATS+f] = req_tdata[knng_pkg::REQ_X_LSB +: 16];
            mir_y[p*FEATS+f] = req_tdata[knng_pkg::REQ_Y_LSB +: 16];
            mir_z[p*FEATS+f] = req_tdata[knng_pkg::REQ_Z_LSB +: 16];
            mir_label[p]     = req_tdata[knng_pkg::REQ_LB_LSB +: 4];
         end else begin
            qry_x[f] = req_tdata[knng_pkg::REQ_X_LSB +: 16];
            qry_y[f] = req_tdata[knng_pkg::REQ_Y_LSB +: 16];
            qry_z[f] = req_tdata[knng_pkg::REQ_Z_LSB +: 16];
            if (req_tlast) verdicts_due.push_back(classify_gesture());
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         verdicts_seen++;
         if (verdicts_due.size() == 0) begin
            $error("unexpected result transfer: gesture_class %0d vote_total %0d",
                   rsp_tdata[3:0], rsp_tdata[7:4]);
            failures++;
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_tdata[3:0] !== want.gesture) begin
               $error("gesture_class: expected %0d, got %0d", want.gesture, rsp_tdata[3:0]);
               failures++;
            end
            if (rsp_tdata[7:4] !== want.votes) begin
               $error("vote_total: expected %0d, got %0d", want.votes, rsp_tdata[7:4]);
               failures++;
            end
         end
      end
      // Watchdog: count cycles of pending work with no transfer on either side
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (feature_feed.size() == 0 && !req_tvalid && verdicts_due.size() == 0))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WDOG_MAX) begin
         $display("watchdog expired with %0d results outstanding", verdicts_due.size());
         $display("end of test: mismatches");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   function automatic int idle_draw(input bit burst);
      return burst ? 0 : $urandom_range(0, 18);
   endfunction

   // Request driver: hold each transfer until taken, then idle for a drawn gap
   int gap_left = 0;
   bit send_burst = 1'b0;

   always @(negedge clock) begin
      feature_type it;
      logic        next_valid;
      if (!reset && !(req_tvalid && !req_took)) begin
         if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (feature_feed.size() != 0) begin
            it = feature_feed.pop_front();
            req_tdata  <= {6'd0, it.label, it.sz, it.sy, it.sx, it.feat, it.point};
            req_tuser  <= it.cmd;
            req_tlast  <= it.last;
            next_valid = 1'b1;
            gap_left   = idle_draw(send_burst);
            features_sent++;
         end
         req_tvalid <= next_valid;
      end
   end

   // Result receiver: stall for a drawn number of cycles before each transfer
   int stall_left = 0;
   bit take_burst = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_took) begin
            if ($urandom_range(0, 29) == 0) take_burst = ~take_burst;
            stall_left = idle_draw(take_burst);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [15:0] pick_sample(input int mode);
      case (mode)
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(0, 4) - 2);
         default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      endcase
   endfunction

   task automatic push_feature(input logic cmd, input int p, input int f, input int mode,
                               input logic [3:0] lab, input logic last);
      feature_type it;
      it.cmd   = cmd;
      it.point = p[7:0];
      it.feat  = f[5:0];
      it.sx    = pick_sample(mode);
      it.sy    = pick_sample(mode);
      it.sz    = pick_sample(mode);
      it.label = lab;
      it.last  = last;
      if (cmd == knng_pkg::CMD_TRAIN) begin
         trained[p*FEATS+f] = 1'b1;
         labelled[p]        = 1'b1;
      end else begin
         queried[f] = 1'b1;
      end
      feature_feed.push_back(it);
   endtask

   // Pause the sender until the block is drained, then let it settle
   task automatic drain();
      while (feature_feed.size() != 0 || req_tvalid || verdicts_due.size() != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value[knng_pkg::CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic configure(input int nf, input int nt, input int nc, input int k);
      drain();
      write_reg(knng_pkg::REG_NUM_FEATURES, nf);
      write_reg(knng_pkg::REG_NUM_TRAINING, nt);
      write_reg(knng_pkg::REG_NUM_CLASSES, nc);
      write_reg(knng_pkg::REG_NEIGHBOR_COUNT, k);
      @(negedge clock);
      phases_run++;
   endtask

   // One phase: fill every training entry in use, then run a set of queries
   task automatic run_phase(input int nf, input int nt, input int nc, input int k);
      int mode, nq, order[$], tmp, j, pushed;
      configure(nf, nt, nc, k);
      mode = $urandom_range(0, 5);
      mode = (mode < 3) ? 0 : (mode < 5) ? 1 : 2;
      for (int p = 0; p < nt; p++)
         for (int f = 0; f < nf; f++)
            if (!trained[p*FEATS+f] || !labelled[p] || $urandom_range(0, 3) == 0)
               push_feature(knng_pkg::CMD_TRAIN, p, f, mode, 4'($urandom), 1'b0);
      nq = $urandom_range(2, 8);
      for (int q = 0; q < nq; q++) begin
         // noise: stray training rewrites and query writes beyond the features in use
         if ($urandom_range(0, 3) == 0)
            push_feature(knng_pkg::CMD_TRAIN, $urandom_range(0, 255),
                         $urandom_range(0, 63), mode, 4'($urandom), 1'b0);
         if ($urandom_range(0, 3) == 0 && nf < FEATS)
            push_feature(knng_pkg::CMD_QUERY, $urandom, $urandom_range(nf, 63), mode,
                         4'($urandom), 1'b0);
         order.delete();
         for (int f = 0; f < nf; f++) order.push_back(f);
         for (int i = nf - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i]; order[i] = order[j]; order[j] = tmp;
         end
         // keep some earlier query features stale; at least the final one is sent
         pushed = 0;
         for (int i = 0; i < nf; i++) begin
            if (i == nf - 1 || !queried[order[i]] || $urandom_range(0, 4) != 0) begin
               push_feature(knng_pkg::CMD_QUERY, $urandom, order[i], mode, 4'($urandom),
                            i == nf - 1);
               pushed++;
            end
         end
      end
   endtask

   initial begin
      int nf, nt;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extreme samples, a vote tie between classes, labels above the class limit
      configure(1, 2, 15, 2);
      push_feature(knng_pkg::CMD_TRAIN, 0, 0, 2, 4'd15, 1'b0);
      feature_feed[$].sx = 16'h7FFF; feature_feed[$].sy = 16'h7FFF;
      feature_feed[$].sz = 16'h7FFF;
      push_feature(knng_pkg::CMD_TRAIN, 1, 0, 2, 4'd3, 1'b0);
      feature_feed[$].sx = 16'h8000; feature_feed[$].sy = 16'h8000;
      feature_feed[$].sz = 16'h8000;
      push_feature(knng_pkg::CMD_QUERY, 0, 0, 2, 4'd0, 1'b1);
      feature_feed[$].sx = 16'h8000; feature_feed[$].sy = 16'h8000;
      feature_feed[$].sz = 16'h8000;
      push_feature(knng_pkg::CMD_QUERY, 255, 0, 1, 4'd15, 1'b1);
      feature_feed[$].sx = 16'h0000; feature_feed[$].sy = 16'h0000;
      feature_feed[$].sz = 16'h0000;
      configure(1, 2, 0, 1);
      push_feature(knng_pkg::CMD_QUERY, 0, 0, 2, 4'd0, 1'b1);
      feature_feed[$].sx = 16'h7FFF; feature_feed[$].sy = 16'h7FFF;
      feature_feed[$].sz = 16'h7FFF;
      configure(1, 2, 15, 15);
      push_feature(knng_pkg::CMD_QUERY, 0, 0, 1, 4'd0, 1'b1);

      // Extreme register settings
      run_phase(64, 2, 15, 15);
      run_phase(1, 256, 15, 15);
      run_phase(1, 1, 0, 1);

      // Random phases, mostly small so the walks stay short
      while (features_sent + feature_feed.size() < 2000) begin
         nf = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 8);
         nt = (nf == 64) ? $urandom_range(1, 3) : $urandom_range(1, 24);
         run_phase(nf, nt, $urandom_range(0, 15), $urandom_range(1, 15));
      end
      drain();

      $display("covered %0d feature transfers and %0d classifications over %0d settings",
               features_sent, verdicts_seen, phases_run);
      if (failures == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
